FILE: rtl/core/efla_pkg.sv
`timescale 1ns / 1ps

package efla_pkg;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OOM  = 2'd2;

  // register index of extend_chunk_bytes
  localparam logic REG_CHUNK = 1'b0;

  localparam int unsigned MIN_BLOCK   = 24;
  localparam int unsigned ADDR_LIMIT  = 262144;
  localparam logic [18:0] CHUNK_RESET = 19'd4096;

  // one access to the heap memory, word addressed
  typedef struct packed {
    logic        en;
    logic        we;
    logic [29:0] word;
    logic [31:0] wdata;
  } mem_req_t;

  // one result word
  typedef struct packed {
    logic [17:0] addr;
    logic [1:0]  status;
  } res_t;

endpackage

FILE: rtl/core/efla_ram.sv
`timescale 1ns / 1ps

module efla_ram #(
  parameter int unsigned DEPTH = 65536
) (
  input  logic                clk_i,
  input  efla_pkg::mem_req_t  req_i,
  output logic [31:0]         rdata_o
);
  import efla_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      if (req_i.we) begin
        mem[req_i.word[AW-1:0]] <= req_i.wdata;
      end else begin
        rdata_o <= mem[req_i.word[AW-1:0]];
      end
    end
  end

endmodule

FILE: rtl/core/efla_ctrl.sv
`timescale 1ns / 1ps

module efla_ctrl #(
  parameter int unsigned HEAP_WORDS = 65536
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cmd_i,
  input  logic [17:0]         req_i,
  input  logic [17:0]         addr_i,
  input  logic [18:0]         chunk_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output efla_pkg::res_t      res_o,
  output efla_pkg::mem_req_t  mem_req_o,
  input  logic [31:0]         mem_rdata_i
);
  import efla_pkg::*;

  localparam int unsigned IW    = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int unsigned CAP   = (4 * HEAP_WORDS > ADDR_LIMIT) ? ADDR_LIMIT : 4 * HEAP_WORDS;
  localparam int unsigned LIMIT = CAP / 8 + 2;
  localparam int unsigned CW    = $clog2(LIMIT + 1);
  localparam int unsigned NS    = 71;

  typedef enum logic [NS-1:0] {
    S_CLR  = NS'(1) << 0,
    S_I0   = NS'(1) << 1,
    S_I1   = NS'(1) << 2,
    S_I2   = NS'(1) << 3,
    S_IDLE = NS'(1) << 4,
    S_DONE = NS'(1) << 5,
    S_F1   = NS'(1) << 6,
    S_F2   = NS'(1) << 7,
    S_F3   = NS'(1) << 8,
    S_G0   = NS'(1) << 9,
    S_G1   = NS'(1) << 10,
    S_G2   = NS'(1) << 11,
    S_AG   = NS'(1) << 12,
    S_T0   = NS'(1) << 13,
    S_T1   = NS'(1) << 14,
    S_T2   = NS'(1) << 15,
    S_T3   = NS'(1) << 16,
    S_T5   = NS'(1) << 17,
    S_T6   = NS'(1) << 18,
    S_T7   = NS'(1) << 19,
    S_T8   = NS'(1) << 20,
    S_T9   = NS'(1) << 21,
    S_T10  = NS'(1) << 22,
    S_M0   = NS'(1) << 23,
    S_M1   = NS'(1) << 24,
    S_M2   = NS'(1) << 25,
    S_M3   = NS'(1) << 26,
    S_M4   = NS'(1) << 27,
    S_M5   = NS'(1) << 28,
    S_A0   = NS'(1) << 29,
    S_A1   = NS'(1) << 30,
    S_A2   = NS'(1) << 31,
    S_A3   = NS'(1) << 32,
    S_A4   = NS'(1) << 33,
    S_A5   = NS'(1) << 34,
    S_A6   = NS'(1) << 35,
    S_B0   = NS'(1) << 36,
    S_B1   = NS'(1) << 37,
    S_B2   = NS'(1) << 38,
    S_B3   = NS'(1) << 39,
    S_B4   = NS'(1) << 40,
    S_B5   = NS'(1) << 41,
    S_B6   = NS'(1) << 42,
    S_B7   = NS'(1) << 43,
    S_B8   = NS'(1) << 44,
    S_B9   = NS'(1) << 45,
    S_C0   = NS'(1) << 46,
    S_C1   = NS'(1) << 47,
    S_C2   = NS'(1) << 48,
    S_C3   = NS'(1) << 49,
    S_C4   = NS'(1) << 50,
    S_C5   = NS'(1) << 51,
    S_C6   = NS'(1) << 52,
    S_C7   = NS'(1) << 53,
    S_C8   = NS'(1) << 54,
    S_C9   = NS'(1) << 55,
    S_C10  = NS'(1) << 56,
    S_C11  = NS'(1) << 57,
    S_C12  = NS'(1) << 58,
    S_C13  = NS'(1) << 59,
    S_LR0  = NS'(1) << 60,
    S_LR1  = NS'(1) << 61,
    S_LR2  = NS'(1) << 62,
    S_LR3  = NS'(1) << 63,
    S_LP0  = NS'(1) << 64,
    S_LP1  = NS'(1) << 65,
    S_LP2  = NS'(1) << 66,
    S_FR0  = NS'(1) << 67,
    S_FR1  = NS'(1) << 68,
    S_FR2  = NS'(1) << 69,
    S_FR3  = NS'(1) << 70
  } state_e;

  state_e state_q, state_d, ret_lr_q, ret_lr_d, ret_lp_q, ret_lp_d, ret_mg_q, ret_mg_d;

  logic [31:0] p_q, p_d, t_q, t_d, sz_q, sz_d, pv_q, pv_d, nx_q, nx_d;
  logic [31:0] have_q, have_d, head_q, head_d;
  logic [18:0] need_q, need_d, hend_q, hend_d;
  logic [19:0] g_q, g_d;
  logic [17:0] res_q, res_d;
  logic [1:0]  st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] clr_q, clr_d;
  logic        pu_q, pu_d, rd_ok_q, rd_ok_d;

  logic        acc_en, acc_we, in_range;
  logic [31:0] acc_addr, acc_wdata, rd, rsz;
  logic [18:0] ext;
  logic [20:0] grow_end;

  function automatic logic [31:0] tsz(input logic [31:0] x);
    return {x[31:3], 3'b000};
  endfunction

  // cut to whole words, then round up to an even word count
  function automatic logic [19:0] growth(input logic [18:0] e);
    logic [16:0] w;
    w = e[18:2];
    return {18'(w) + 18'(w[0]), 2'b00};
  endfunction

  // reads outside the memory give zero
  assign rd  = rd_ok_q ? mem_rdata_i : 32'd0;
  assign rsz = tsz(rd);
  assign ext = (need_q > chunk_i) ? need_q : chunk_i;
  assign grow_end = 21'(hend_q) + 21'(g_q);

  always_comb begin
    state_d  = state_q;
    ret_lr_d = ret_lr_q;
    ret_lp_d = ret_lp_q;
    ret_mg_d = ret_mg_q;
    p_d      = p_q;
    t_d      = t_q;
    sz_d     = sz_q;
    pv_d     = pv_q;
    nx_d     = nx_q;
    have_d   = have_q;
    head_d   = head_q;
    need_d   = need_q;
    hend_d   = hend_q;
    g_d      = g_q;
    res_d    = res_q;
    st_d     = st_q;
    cnt_d    = cnt_q;
    clr_d    = clr_q;
    pu_d     = pu_q;
    acc_en    = 1'b0;
    acc_we    = 1'b0;
    acc_addr  = 32'd0;
    acc_wdata = 32'd0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      S_CLR: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = 32'(clr_q) << 2;
        clr_d = clr_q + 1'b1;
        if (clr_q == IW'(HEAP_WORDS - 1)) state_d = S_I0;
      end
      // prologue and epilogue tags
      S_I0: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = 32'd4; acc_wdata = 32'd17;
        state_d = S_I1;
      end
      S_I1: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = 32'd16; acc_wdata = 32'd17;
        state_d = S_I2;
      end
      S_I2: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = 32'd20; acc_wdata = 32'd1;
        g_d = growth(CHUNK_RESET);
        ret_mg_d = S_IDLE;
        state_d = S_G0;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          st_d  = ST_OK;
          if (cmd_i == CMD_FREE) begin
            p_d = 32'(addr_i);
            state_d = S_FR0;
          end else if (req_i == 18'd0) begin
            st_d = ST_ZERO;
            state_d = S_DONE;
          end else begin
            need_d = (req_i <= 18'd8) ? 19'(MIN_BLOCK)
                                      : ((19'(req_i) + 19'd23) & ~19'd7);
            p_d = head_q;
            cnt_d = '0;
            state_d = S_F1;
          end
        end
      end
      S_DONE: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = S_IDLE;
      end
      // first-fit walk
      S_F1: begin
        if (cnt_q == CW'(LIMIT)) begin
          g_d = growth(ext); ret_mg_d = S_AG; state_d = S_G0;
        end else begin
          acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_F2;
        end
      end
      S_F2: begin
        if (rd[0]) begin
          g_d = growth(ext); ret_mg_d = S_AG; state_d = S_G0;
        end else if (32'(need_q) <= rsz) begin
          res_d = p_q[17:0]; state_d = S_T0;
        end else begin
          acc_en = 1'b1; acc_addr = p_q + 32'd4; state_d = S_F3;
        end
      end
      S_F3: begin
        p_d = rd; cnt_d = cnt_q + 1'b1; state_d = S_F1;
      end
      // heap growth
      S_G0: begin
        if (g_q > 20'(CAP) || grow_end > 21'(CAP)) begin
          p_d = '0; state_d = ret_mg_q;
        end else begin
          p_d = 32'(hend_q);
          acc_en = 1'b1; acc_we = 1'b1;
          acc_addr = 32'(hend_q) - 32'd4; acc_wdata = 32'(g_q);
          state_d = S_G1;
        end
      end
      S_G1: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + 32'(g_q) - 32'd8; acc_wdata = 32'(g_q);
        state_d = S_G2;
      end
      S_G2: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + 32'(g_q) - 32'd4; acc_wdata = 32'd1;
        hend_d = grow_end[18:0];
        state_d = S_M0;
      end
      S_AG: begin
        if (p_q == 32'd0) begin
          st_d = ST_OOM; state_d = S_DONE;
        end else begin
          res_d = p_q[17:0]; state_d = S_T0;
        end
      end
      // take a free block, split when the rest is big enough
      S_T0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_T1;
      end
      S_T1: begin
        have_d = rsz;
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q - 32'd4;
        if (rsz - 32'(need_q) >= 32'(MIN_BLOCK)) begin
          acc_wdata = 32'(need_q) | 32'd1; state_d = S_T2;
        end else begin
          acc_wdata = rsz | 32'd1; state_d = S_T9;
        end
      end
      S_T2: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_T3;
      end
      S_T3: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + rsz - 32'd8; acc_wdata = 32'(need_q) | 32'd1;
        t_d = p_q; ret_lr_d = S_T5; state_d = S_LR0;
      end
      S_T5: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_T6;
      end
      S_T6: begin
        p_d = p_q + rsz;
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + rsz - 32'd4; acc_wdata = have_q - 32'(need_q);
        state_d = S_T7;
      end
      S_T7: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_T8;
      end
      S_T8: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + rsz - 32'd8; acc_wdata = have_q - 32'(need_q);
        ret_lp_d = S_DONE; state_d = S_LP0;
      end
      S_T9: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_T10;
      end
      S_T10: begin
        acc_en = 1'b1; acc_we = 1'b1;
        acc_addr = p_q + rsz - 32'd8; acc_wdata = have_q | 32'd1;
        t_d = p_q; ret_lr_d = S_DONE; state_d = S_LR0;
      end
      // coalesce: probe both neighbors
      S_M0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_M1;
      end
      S_M1: begin
        t_d = p_q - rsz;
        acc_en = 1'b1; acc_addr = p_q - rsz - 32'd4; state_d = S_M2;
      end
      S_M2: begin
        acc_en = 1'b1; acc_addr = t_q + rsz - 32'd8; state_d = S_M3;
      end
      S_M3: begin
        pu_d = rd[0];
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_M4;
      end
      S_M4: begin
        sz_d = rsz;
        acc_en = 1'b1; acc_addr = p_q + rsz - 32'd4; state_d = S_M5;
      end
      S_M5: begin
        case ({pu_q, rd[0]})
          2'b11:   begin ret_lp_d = ret_mg_q; state_d = S_LP0; end
          2'b10:   state_d = S_A0;
          2'b01:   state_d = S_B0;
          default: state_d = S_C0;
        endcase
      end
      // next neighbor free
      S_A0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_A1;
      end
      S_A1: begin
        t_d = p_q + rsz; ret_lr_d = S_A2; state_d = S_LR0;
      end
      S_A2: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_A3;
      end
      S_A3: begin
        acc_en = 1'b1; acc_addr = p_q + rsz - 32'd4; state_d = S_A4;
      end
      S_A4: begin
        sz_d = sz_q + rsz;
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q - 32'd4; acc_wdata = sz_q + rsz;
        state_d = S_A5;
      end
      S_A5: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_A6;
      end
      S_A6: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q + rsz - 32'd8; acc_wdata = sz_q;
        ret_lp_d = ret_mg_q; state_d = S_LP0;
      end
      // previous neighbor free
      S_B0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_B1;
      end
      S_B1: begin
        t_d = p_q - rsz; ret_lr_d = S_B2; state_d = S_LR0;
      end
      S_B2: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_B3;
      end
      S_B3: begin
        acc_en = 1'b1; acc_addr = p_q - rsz - 32'd4; state_d = S_B4;
      end
      S_B4: begin
        sz_d = sz_q + rsz;
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_B5;
      end
      S_B5: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q - rsz - 32'd4; acc_wdata = sz_q;
        state_d = S_B6;
      end
      S_B6: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_B7;
      end
      S_B7: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q + rsz - 32'd8; acc_wdata = sz_q;
        state_d = S_B8;
      end
      // step back to the previous block, then push
      S_B8: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_B9;
      end
      S_B9: begin
        p_d = p_q - rsz; ret_lp_d = ret_mg_q; state_d = S_LP0;
      end
      // both neighbors free
      S_C0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_C1;
      end
      S_C1: begin
        t_d = p_q + rsz; ret_lr_d = S_C2; state_d = S_LR0;
      end
      S_C2: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_C3;
      end
      S_C3: begin
        t_d = p_q - rsz; ret_lr_d = S_C4; state_d = S_LR0;
      end
      S_C4: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_C5;
      end
      S_C5: begin
        acc_en = 1'b1; acc_addr = p_q - rsz - 32'd4; state_d = S_C6;
      end
      S_C6: begin
        sz_d = sz_q + rsz;
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_C7;
      end
      S_C7: begin
        t_d = p_q + rsz;
        acc_en = 1'b1; acc_addr = p_q + rsz - 32'd4; state_d = S_C8;
      end
      S_C8: begin
        acc_en = 1'b1; acc_addr = t_q + rsz - 32'd8; state_d = S_C9;
      end
      S_C9: begin
        sz_d = sz_q + rsz;
        acc_en = 1'b1; acc_addr = p_q - 32'd8; state_d = S_C10;
      end
      S_C10: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q - rsz - 32'd4; acc_wdata = sz_q;
        state_d = S_C11;
      end
      S_C11: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_C12;
      end
      S_C12: begin
        t_d = p_q + rsz;
        acc_en = 1'b1; acc_addr = p_q + rsz - 32'd4; state_d = S_C13;
      end
      S_C13: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = t_q + rsz - 32'd8; acc_wdata = sz_q;
        state_d = S_B8;
      end
      // unlink t from the free list
      S_LR0: begin
        acc_en = 1'b1; acc_addr = t_q; state_d = S_LR1;
      end
      S_LR1: begin
        pv_d = rd;
        acc_en = 1'b1; acc_addr = t_q + 32'd4; state_d = S_LR2;
      end
      S_LR2: begin
        nx_d = rd;
        acc_en = 1'b1; acc_we = 1'b1;
        if (t_q == head_q) begin
          acc_addr = rd; acc_wdata = 32'd0;
          head_d = rd; state_d = ret_lr_q;
        end else begin
          acc_addr = pv_q + 32'd4; acc_wdata = rd;
          state_d = S_LR3;
        end
      end
      S_LR3: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = nx_q; acc_wdata = pv_q;
        state_d = ret_lr_q;
      end
      // push p at the list head
      S_LP0: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = head_q; acc_wdata = p_q;
        state_d = S_LP1;
      end
      S_LP1: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q; acc_wdata = 32'd0;
        state_d = S_LP2;
      end
      S_LP2: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q + 32'd4; acc_wdata = head_q;
        head_d = p_q; state_d = ret_lp_q;
      end
      // free: validate the header, clear the allocated bit
      S_FR0: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_FR1;
      end
      S_FR1: begin
        if (p_q >= 32'(MIN_BLOCK) && p_q < 32'(hend_q) && p_q[2:0] == 3'd0 &&
            rd[0] && rsz >= 32'(MIN_BLOCK)) begin
          sz_d = rsz;
          acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q - 32'd4; acc_wdata = rsz;
          state_d = S_FR2;
        end else begin
          state_d = S_DONE;
        end
      end
      S_FR2: begin
        acc_en = 1'b1; acc_addr = p_q - 32'd4; state_d = S_FR3;
      end
      S_FR3: begin
        acc_en = 1'b1; acc_we = 1'b1; acc_addr = p_q + rsz - 32'd8; acc_wdata = sz_q;
        ret_mg_d = S_DONE; state_d = S_M0;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // accesses past the end of the memory are dropped
  assign in_range = {2'b00, acc_addr[31:2]} < 32'(HEAP_WORDS);
  assign rd_ok_d  = acc_en & ~acc_we & in_range;

  assign mem_req_o.en    = acc_en & in_range;
  assign mem_req_o.we    = acc_we;
  assign mem_req_o.word  = acc_addr[31:2];
  assign mem_req_o.wdata = acc_wdata;

  assign res_o.addr   = res_q;
  assign res_o.status = st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLR;
      ret_lr_q <= S_IDLE;
      ret_lp_q <= S_IDLE;
      ret_mg_q <= S_IDLE;
      head_q   <= 32'd8;
      hend_q   <= 19'(MIN_BLOCK);
      clr_q    <= '0;
      cnt_q    <= '0;
      rd_ok_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ret_lr_q <= ret_lr_d;
      ret_lp_q <= ret_lp_d;
      ret_mg_q <= ret_mg_d;
      head_q   <= head_d;
      hend_q   <= hend_d;
      clr_q    <= clr_d;
      cnt_q    <= cnt_d;
      rd_ok_q  <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    t_q    <= t_d;
    sz_q   <= sz_d;
    pv_q   <= pv_d;
    nx_q   <= nx_d;
    have_q <= have_d;
    need_q <= need_d;
    g_q    <= g_d;
    res_q  <= res_d;
    st_q   <= st_d;
    pu_q   <= pu_d;
  end

endmodule

FILE: rtl/core/explicit_free_list_allocator.sv
`timescale 1ns / 1ps

// heap allocator with boundary tags and a lifo explicit free list, first fit.
// each input word is an allocate (tuser 0) or a free (tuser 1) and gives
// exactly one output word: the granted payload offset and a status
// (0 ok, 1 zero-size request, 2 out of heap). all tags and links sit in one
// single-port word memory with a registered read port, so the request runs as
// a sequence of tag and link accesses: a free does more work the more
// neighbors merge and stops after the header check when it is ignored; an
// allocate walks the free list block by block, grows the heap when no block
// fits, then splits and relinks. one request is in work at a time; a finished
// word waits in an output register while the next request is taken. after
// reset the block clears the memory, one word per cycle, then lays down the
// prologue, epilogue and first chunk before tready rises. extend_chunk_bytes
// sits at apb byte address 0 and sets the minimum growth of the heap.

module explicit_free_list_allocator #(
  parameter int unsigned HEAP_WORDS = 65536
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // request_bytes [17:0], block_address [35:18]
  input  logic [0:0]  s_axis_tuser,   // command [0]
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // result_address [17:0], status [19:18]
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import efla_pkg::*;

  logic [18:0] chunk_q;
  logic        out_valid, out_ready;
  res_t        res;
  mem_req_t    mem_req;
  logic [31:0] mem_rdata;
  logic        m_valid_q;
  res_t        m_data_q;

  // configuration register, writes complete in the access phase
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHUNK) ? 32'(chunk_q) : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= CHUNK_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHUNK) begin
      chunk_q <= pwdata[18:0];
    end
  end

  efla_ctrl #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .cmd_i       (s_axis_tuser[0]),
    .req_i       (s_axis_tdata[17:0]),
    .addr_i      (s_axis_tdata[35:18]),
    .chunk_i     (chunk_q),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  efla_ram #(
    .DEPTH (HEAP_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  // output register frees the sequencer while the result waits
  assign out_ready = !m_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_ready) begin
      m_valid_q <= out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && out_valid) begin
      m_data_q <= res;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_data_q.status, m_data_q.addr};

endmodule

FILE: dv/explicit_free_list_allocator_tb.sv
`timescale 1ns / 1ps

module explicit_free_list_allocator_tb;
  import efla_pkg::*;

  localparam int unsigned HEAP_W    = 65536;
  localparam int unsigned HEAP_CAP  = (4 * HEAP_W > ADDR_LIMIT) ? ADDR_LIMIT : 4 * HEAP_W;
  localparam int unsigned CYC_LIMIT = 20000000;

  typedef struct {
    logic        cmd;
    logic [17:0] req_bytes;
    logic [17:0] blk_addr;
  } heap_req_t;

  typedef struct {
    logic [17:0] addr;
    logic [1:0]  status;
  } grant_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // request_bytes [17:0], block_address [35:18]
  logic [0:0]  s_axis_tuser;   // command [0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // result_address [17:0], status [19:18]
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  explicit_free_list_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // shadow heap and allocator state
  logic [31:0] heap_img [HEAP_W];
  int unsigned list_head;
  int unsigned heap_top;
  int unsigned chunk_bytes;

  heap_req_t   pend_q[$];     // words waiting for the driver
  grant_t      grant_q[$];    // results still owed by the block
  int unsigned live_q[$];     // payload offsets currently granted
  int unsigned errors;
  int unsigned cycles;

  // driver and sink state
  heap_req_t   cur_word;
  bit          word_busy;
  int unsigned send_gap;
  int unsigned sink_gap;
  int unsigned hold_left;
  bit          hold_req;
  bit          hold_done;
  bit          quiet;         // no idling on either side while set

  // ---------------------------------------------------------------------------
  // heap predictor
  // ---------------------------------------------------------------------------
  function automatic logic [31:0] hp_rd(int unsigned a);
    int unsigned i;
    i = a >> 2;
    return (i < HEAP_W) ? heap_img[i] : 32'd0;
  endfunction

  function automatic void hp_wr(int unsigned a, int unsigned v);
    int unsigned i;
    i = a >> 2;
    if (i < HEAP_W) heap_img[i] = v;
  endfunction

  function automatic int unsigned tag_sz(int unsigned a);
    return hp_rd(a) & ~32'd7;
  endfunction

  function automatic bit tag_alloc(int unsigned a);
    return hp_rd(a) & 32'd1;
  endfunction

  // header, footer and neighbors of a block by its payload offset
  function automatic int unsigned hdr_of(int unsigned p);
    return p - 4;
  endfunction

  function automatic int unsigned ftr_of(int unsigned p);
    return p + tag_sz(p - 4) - 8;
  endfunction

  function automatic int unsigned next_blk(int unsigned p);
    return p + tag_sz(p - 4);
  endfunction

  function automatic int unsigned prev_blk(int unsigned p);
    return p - tag_sz(p - 8);
  endfunction

  function automatic void link_front(int unsigned p);
    hp_wr(list_head, p);
    hp_wr(p, 0);
    hp_wr(p + 4, list_head);
    list_head = p;
  endfunction

  function automatic void unlink(int unsigned p);
    int unsigned pv, nx;
    pv = hp_rd(p);
    nx = hp_rd(p + 4);
    if (p == list_head) begin
      hp_wr(nx, 0);
      list_head = nx;
    end else begin
      hp_wr(pv + 4, nx);
      hp_wr(nx, pv);
    end
  endfunction

  // four-way coalesce, then push the merged block at the list head
  function automatic int unsigned coalesce(int unsigned p);
    bit          pu, nu;
    int unsigned sz;
    pu = tag_alloc(ftr_of(prev_blk(p)));
    nu = tag_alloc(hdr_of(next_blk(p)));
    sz = tag_sz(hdr_of(p));
    if (pu && !nu) begin
      unlink(next_blk(p));
      sz += tag_sz(hdr_of(next_blk(p)));
      hp_wr(hdr_of(p), sz);
      hp_wr(ftr_of(p), sz);
    end else if (!pu && nu) begin
      unlink(prev_blk(p));
      sz += tag_sz(hdr_of(prev_blk(p)));
      hp_wr(hdr_of(prev_blk(p)), sz);
      hp_wr(ftr_of(p), sz);
      p = prev_blk(p);
    end else if (!pu && !nu) begin
      unlink(next_blk(p));
      unlink(prev_blk(p));
      sz += tag_sz(hdr_of(prev_blk(p)));
      sz += tag_sz(ftr_of(next_blk(p)));
      hp_wr(hdr_of(prev_blk(p)), sz);
      hp_wr(ftr_of(next_blk(p)), sz);
      p = prev_blk(p);
    end
    link_front(p);
    return p;
  endfunction

  function automatic int unsigned grow_heap(int unsigned sz);
    int unsigned p;
    p = heap_top;
    if (sz > HEAP_CAP || p > HEAP_CAP - sz) return 0;
    hp_wr(p - 4, sz);
    hp_wr(p + sz - 8, sz);
    hp_wr(p + sz - 4, 1);
    heap_top = p + sz;
    return coalesce(p);
  endfunction

  // cut to words, then up to an even word count
  function automatic int unsigned grow_amount(int unsigned ext);
    int unsigned w;
    w = ext >> 2;
    if (w & 1) w++;
    return w * 4;
  endfunction

  function automatic int unsigned first_free(int unsigned need);
    int unsigned p, n;
    p = list_head;
    for (n = 0; n < HEAP_CAP / 8 + 2 && !tag_alloc(hdr_of(p)); n++) begin
      if (need <= tag_sz(hdr_of(p))) return p;
      p = hp_rd(p + 4);
    end
    return 0;
  endfunction

  function automatic void carve(int unsigned p, int unsigned need);
    int unsigned have;
    have = tag_sz(hdr_of(p));
    if (have - need >= MIN_BLOCK) begin
      hp_wr(hdr_of(p), need | 1);
      hp_wr(ftr_of(p), need | 1);
      unlink(p);
      p = next_blk(p);
      hp_wr(hdr_of(p), have - need);
      hp_wr(ftr_of(p), have - need);
      link_front(p);
    end else begin
      hp_wr(hdr_of(p), have | 1);
      hp_wr(ftr_of(p), have | 1);
      unlink(p);
    end
  endfunction

  function automatic void heap_init();
    int unsigned dummy;
    foreach (heap_img[i]) heap_img[i] = '0;
    hp_wr(4, 16 | 1);
    hp_wr(16, 16 | 1);
    hp_wr(20, 1);
    list_head   = 8;
    heap_top    = 24;
    chunk_bytes = CHUNK_RESET;
    dummy       = grow_heap(grow_amount(CHUNK_RESET));
  endfunction

  // one accepted word in, one expected result out
  function automatic void predict_grant(heap_req_t w);
    grant_t      g;
    int unsigned req, addr, need, p, ext, h, sz;
    req = w.req_bytes;
    addr = w.blk_addr;
    g.addr = '0;
    g.status = ST_OK;
    if (w.cmd == CMD_ALLOC) begin
      if (req == 0) begin
        g.status = ST_ZERO;
      end else begin
        need = (req <= 8) ? MIN_BLOCK : ((req + 16 + 7) & ~32'd7);
        p = first_free(need);
        if (p == 0) begin
          ext = (need > chunk_bytes) ? need : chunk_bytes;
          p = grow_heap(grow_amount(ext));
        end
        if (p == 0) begin
          g.status = ST_OOM;
        end else begin
          carve(p, need);
          g.addr = p[17:0];
          live_q.push_back(p);
        end
      end
    end else begin
      h = hp_rd(addr - 4);
      // bad frees fall through with no change
      if (addr >= MIN_BLOCK && addr < heap_top && (addr & 7) == 0 &&
          h[0] && (h & ~32'd7) >= MIN_BLOCK) begin
        sz = h & ~32'd7;
        hp_wr(hdr_of(addr), sz);
        hp_wr(ftr_of(addr), sz);
        p = coalesce(addr);
      end
    end
    grant_q.push_back(g);
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // clock, cycle limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // request driver: changes at the falling edge, accept seen at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      predict_grant(cur_word);
      word_busy = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !word_busy) begin
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        cur_word = pend_q.pop_front();
        word_busy = 1'b1;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'd0, cur_word.blk_addr, cur_word.req_bytes};
        s_axis_tuser <= cur_word.cmd;
        send_gap = quiet ? 0 : pick_gap();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: random backpressure plus one long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      // long stall so the block fills up and drops s_axis_tready
      hold_done = 1'b1;
      hold_left = 400;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (quiet) begin
      m_axis_tready <= 1'b1;
    end else begin
      sink_gap = pick_gap();
      m_axis_tready <= (sink_gap == 0);
    end
  end

  // monitor: compare each result word with the oldest expectation
  always @(posedge clk_i) begin
    grant_t g;
    if (m_axis_tvalid && m_axis_tready) begin
      if (grant_q.size() == 0) begin
        $display("%0t: unexpected result word addr=%0d status=%0d", $time,
                 m_axis_tdata[17:0], m_axis_tdata[19:18]);
        errors++;
      end else begin
        g = grant_q.pop_front();
        if (m_axis_tdata[17:0] !== g.addr) begin
          $display("%0t: result_address exp=%0d act=%0d", $time, g.addr,
                   m_axis_tdata[17:0]);
          errors++;
        end
        if (m_axis_tdata[19:18] !== g.status) begin
          $display("%0t: status exp=%0d act=%0d", $time, g.status,
                   m_axis_tdata[19:18]);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  task automatic push_word(logic cmd, int unsigned req, int unsigned addr);
    heap_req_t w;
    w.cmd = cmd;
    w.req_bytes = req[17:0];
    w.blk_addr = addr[17:0];
    pend_q.push_back(w);
  endtask

  // hold the sender until every owed result has come back
  task automatic drain();
    while (pend_q.size() > 0 || word_busy || grant_q.size() > 0 || send_gap > 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  task automatic write_chunk(int unsigned v);
    drain();
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = 3'(4 * REG_CHUNK);
    pwdata = v;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    chunk_bytes = v & 32'h7FFFF;
    @(negedge clk_i);
    pwrite = 1'b0;
    penable = 1'b0;
    // read back
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if (prdata[18:0] !== chunk_bytes[18:0]) begin
      $display("%0t: extend_chunk_bytes readback exp=%0d act=%0d", $time,
               chunk_bytes, prdata[18:0]);
      errors++;
    end
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  function automatic int unsigned take_live();
    int unsigned k, a;
    k = $urandom_range(0, live_q.size() - 1);
    a = live_q[k];
    live_q.delete(k);
    return a;
  endfunction

  task automatic random_words(int unsigned n);
    int unsigned r, sz, a;
    repeat (n) begin
      while (pend_q.size() > 3) @(posedge clk_i);
      r = $urandom_range(0, 99);
      if (live_q.size() > 150 && r < 50) r = r + 50;
      if (live_q.size() == 0 && r >= 50 && r < 94) r = 0;
      if (r < 50) begin
        // allocate; block_address is unused here, so it gets noise
        r = $urandom_range(0, 99);
        if (r < 60)      sz = $urandom_range(1, 64);
        else if (r < 92) sz = $urandom_range(65, 1024);
        else if (r < 97) sz = $urandom_range(1025, 16384);
        else if (r < 98) sz = 0;
        else             sz = $urandom_range(0, 262143);
        push_word(CMD_ALLOC, sz, $urandom_range(0, 262143));
      end else if (r < 94) begin
        push_word(CMD_FREE, $urandom_range(0, 262143), take_live());
      end else begin
        // frees that must be ignored
        r = $urandom_range(0, 3);
        case (r)
          0: a = $urandom_range(0, 23);
          1: a = $urandom_range(0, 262143) | $urandom_range(1, 7);
          2: a = $urandom_range(heap_top, 262143) & ~32'd7;
          default: a = 262143;
        endcase
        push_word(CMD_FREE, $urandom_range(0, 262143), a);
      end
    end
  endtask

  initial begin
    int unsigned a0, a1, a4, a5, a6;
    errors = 0;
    cycles = 0;
    word_busy = 1'b0;
    send_gap = 0;
    sink_gap = 0;
    hold_left = 0;
    hold_req = 1'b0;
    hold_done = 1'b0;
    quiet = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    heap_init();
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: sizes at the edges, every coalesce case, ignored frees
    quiet = 1'b1;
    push_word(CMD_ALLOC, 0, 0);
    push_word(CMD_ALLOC, 1, 262143);
    push_word(CMD_ALLOC, 8, 0);
    push_word(CMD_ALLOC, 9, 0);
    push_word(CMD_ALLOC, 100, 0);
    push_word(CMD_ALLOC, 40, 0);
    push_word(CMD_ALLOC, 40, 0);
    push_word(CMD_ALLOC, 40, 0);
    push_word(CMD_ALLOC, 262143, 0);
    drain();
    quiet = 1'b0;
    a0 = live_q[0];
    a1 = live_q[1];
    a4 = live_q[4];
    a5 = live_q[5];
    a6 = live_q[6];
    live_q.delete(6);
    live_q.delete(5);
    live_q.delete(4);
    live_q.delete(1);
    live_q.delete(0);
    push_word(CMD_FREE, 0, a1);      // both neighbors allocated
    push_word(CMD_FREE, 0, a0);      // next neighbor free
    push_word(CMD_FREE, 0, a4);
    push_word(CMD_FREE, 0, a5);      // previous neighbor free
    push_word(CMD_FREE, 0, a6);      // both neighbors free
    push_word(CMD_FREE, 0, a1);      // double free
    push_word(CMD_FREE, 262143, 0);
    push_word(CMD_FREE, 0, 16);
    push_word(CMD_FREE, 0, 262143);
    push_word(CMD_FREE, 0, 262136);
    push_word(CMD_FREE, 0, 25);
    drain();

    // tiny growth steps
    write_chunk(8);
    random_words(350);
    // the sink holds off while words keep coming
    hold_req = 1'b1;
    random_words(150);
    drain();
    // growth always exceeds capacity
    write_chunk(262144);
    random_words(250);
    write_chunk($urandom_range(1, 2048) * 8);
    quiet = 1'b1;
    random_words(150);
    quiet = 1'b0;
    random_words(250);
    write_chunk(4096);
    random_words(300);
    write_chunk(16);
    random_words(150);

    drain();
    repeat (100) @(posedge clk_i);
    if (grant_q.size() != 0) errors++;
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
